### rtl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared constants, codes and controller/datapath types of the servo reply
// frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int DATA_STORE_DEPTH = 16;
  localparam int MAX_ITEMS        = 16;
  localparam int ITEM_LIM         = (DATA_STORE_DEPTH < MAX_ITEMS) ?
                                    DATA_STORE_DEPTH : MAX_ITEMS;
  localparam int STORE_AW         = (DATA_STORE_DEPTH > 1) ? $clog2(DATA_STORE_DEPTH) : 1;

  localparam logic [7:0] HEADER_RESET   = 8'hFF;
  localparam logic [8:0] POS_MAX        = 9'd511;
  localparam logic [8:0] POS_ID         = 9'd2;
  localparam logic [8:0] POS_LENGTH     = 9'd3;
  localparam logic [8:0] POS_ERROR      = 9'd4;
  localparam logic [8:0] POS_FIRST_DATA = 9'd5;
  localparam logic [8:0] CHECKSUM_OFS   = 9'd3;
  localparam logic [7:0] MIN_LENGTH     = 8'd2;

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_FAULT    = 3'd1;
  localparam logic [2:0] STATUS_SHORT    = 3'd2;
  localparam logic [2:0] STATUS_HEADER   = 3'd3;
  localparam logic [2:0] STATUS_CHECKSUM = 3'd4;

  typedef enum logic [2:0] {
    ST_PARSE = 3'b001,
    ST_READ  = 3'b010,
    ST_SEND  = 3'b100
  } sfp_state_e;

  typedef struct packed {
    logic in_ready;   // byte channel ready
    logic take;       // byte transfer this cycle
    logic load_err;   // load error item into output register
    logic start;      // begin data run of a good frame
    logic rd;         // read store at run index
    logic load_item;  // load run item into output register
    logic step;       // advance run index
  } sfp_cmd_t;

  typedef struct packed {
    logic rx_valid;
    logic err_item;   // current byte resolves the frame with an error
    logic good;       // current byte is a matching checksum
    logic at_last;    // run index is on the final item
    logic out_free;   // output register can take an item
  } sfp_stat_t;

endpackage

### rtl/sfp_if.sv
// ----------------------------------------------------------------------------
// sfp_if
// Channel interfaces of the servo reply frame parser: received bytes,
// result items and header register writes.
// ----------------------------------------------------------------------------
interface sfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_buffer;

  modport source (output valid, rx_byte, end_of_buffer, input ready);
  modport sink   (input valid, rx_byte, end_of_buffer, output ready);
endinterface

interface sfp_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] servo_id;
  logic [7:0] servo_error;
  logic [7:0] data_count;
  logic [7:0] data_byte;
  logic [3:0] data_index;
  logic       data_valid;
  logic       last;

  modport source (output valid, status, servo_id, servo_error, data_count, data_byte,
                  data_index, data_valid, last, input ready);
  modport sink   (input valid, status, servo_id, servo_error, data_count, data_byte,
                  data_index, data_valid, last, output ready);
endinterface

interface sfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_value;

  modport source (output valid, header_value, input ready);
  modport sink   (input valid, header_value, output ready);
endinterface

### rtl/sfp_ram.sv
// ----------------------------------------------------------------------------
// sfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sfp_ctrl.sv
// ----------------------------------------------------------------------------
// sfp_ctrl
// Controller: byte intake while parsing, then the read/send run that
// delivers the data items of a good frame.
// ----------------------------------------------------------------------------
module sfp_ctrl import sfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sfp_stat_t stat_i,
  output sfp_cmd_t  cmd_o
);

  sfp_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_PARSE: begin
        cmd_o.in_ready = stat_i.out_free;
        cmd_o.take     = stat_i.rx_valid && stat_i.out_free;
        if (cmd_o.take) begin
          cmd_o.load_err = stat_i.err_item;
          if (stat_i.good) begin
            cmd_o.start = 1'b1;
            state_d     = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_SEND;
      end
      ST_SEND: begin
        if (stat_i.out_free) begin
          cmd_o.load_item = 1'b1;
          if (stat_i.at_last) begin
            state_d = ST_PARSE;
          end else begin
            cmd_o.step = 1'b1;
            state_d    = ST_READ;
          end
        end
      end
      default: state_d = ST_PARSE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_PARSE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/sfp_datapath.sv
// ----------------------------------------------------------------------------
// sfp_datapath
// Frame tracking, checksum, data store and output register of the servo
// reply frame parser.
// ----------------------------------------------------------------------------
module sfp_datapath import sfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfp_rx_if.sink    rx_i,
  sfp_res_if.source res_o,
  sfp_cfg_if.sink   cfg_i,
  input  sfp_cmd_t  cmd_i,
  output sfp_stat_t stat_o
);

  logic [7:0] hdr_q;
  logic [8:0] pos_q;
  logic       hb_q;
  logic       resolved_q;
  logic [7:0] sum_q;
  logic [7:0] id_q, len_q, err_q;

  logic [3:0] emit_cnt_q, last_idx_q;
  logic       nodata_q;

  logic       out_valid_q;
  logic [2:0] o_status_q;
  logic [7:0] o_id_q, o_err_q, o_count_q, o_byte_q;
  logic [3:0] o_index_q;
  logic       o_dvalid_q, o_last_q;

  logic       act, p_lt2, p_ge5;
  logic       v_hdr, v_len, v_ck, v_data, v_eob, ck_ok;
  logic [8:0] idx;
  logic       store_we;
  logic [7:0] ram_rdata;
  logic [7:0] count;
  logic [7:0] count_m1;
  logic [3:0] last_idx_d;
  logic [2:0] err_status;

  assign cfg_i.ready = 1'b1;
  assign rx_i.ready  = cmd_i.in_ready;

  // Byte classification
  assign act    = !resolved_q;
  assign p_lt2  = (pos_q < POS_ID);
  assign p_ge5  = (pos_q >= POS_FIRST_DATA);
  assign v_hdr  = act && p_ge5 && hb_q;
  assign v_len  = act && p_ge5 && !hb_q && (len_q < MIN_LENGTH);
  assign v_ck   = act && p_ge5 && !hb_q && (len_q >= MIN_LENGTH) &&
                  (pos_q == ({1'b0, len_q} + CHECKSUM_OFS));
  assign v_data = act && p_ge5 && !hb_q && (len_q >= MIN_LENGTH) && !v_ck;
  assign ck_ok  = (~sum_q == rx_i.rx_byte);
  assign v_eob  = act && !(v_hdr || v_len || v_ck) && rx_i.end_of_buffer;
  assign idx    = pos_q - POS_FIRST_DATA;

  assign store_we = cmd_i.take && v_data && (idx < 9'(DATA_STORE_DEPTH));

  always_comb begin
    priority if (v_hdr) begin
      err_status = STATUS_HEADER;
    end else if (v_ck) begin
      err_status = STATUS_CHECKSUM;
    end else begin
      err_status = STATUS_SHORT;
    end
  end

  assign stat_o.rx_valid = rx_i.valid;
  assign stat_o.err_item = v_hdr || v_len || v_eob || (v_ck && !ck_ok);
  assign stat_o.good     = v_ck && ck_ok;
  assign stat_o.at_last  = (emit_cnt_q == last_idx_q);
  assign stat_o.out_free = !out_valid_q || res_o.ready;

  // Items of the data run
  assign count    = len_q - MIN_LENGTH;
  assign count_m1 = count - 8'd1;
  always_comb begin
    priority if (count == 8'd0) begin
      last_idx_d = 4'd0;
    end else if (count >= 8'(ITEM_LIM)) begin
      last_idx_d = 4'(ITEM_LIM - 1);
    end else begin
      last_idx_d = count_m1[3:0];
    end
  end

  sfp_ram #(
    .WIDTH (8),
    .DEPTH (DATA_STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (STORE_AW'(idx)),
    .wdata_i (rx_i.rx_byte),
    .re_i    (cmd_i.rd),
    .raddr_i (STORE_AW'(emit_cnt_q)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= HEADER_RESET;
    end else if (cfg_i.valid) begin
      hdr_q <= cfg_i.header_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hb_q       <= 1'b0;
      resolved_q <= 1'b0;
      sum_q      <= '0;
    end else if (cmd_i.take) begin
      if (rx_i.end_of_buffer) begin
        pos_q      <= '0;
        hb_q       <= 1'b0;
        resolved_q <= 1'b0;
        sum_q      <= '0;
      end else if (act) begin
        if (pos_q != POS_MAX) begin
          pos_q <= pos_q + 9'd1;
        end
        if (p_lt2 && (rx_i.rx_byte != hdr_q)) begin
          hb_q <= 1'b1;
        end
        if ((!p_lt2 && !p_ge5) || v_data) begin
          sum_q <= sum_q + rx_i.rx_byte;
        end
        resolved_q <= v_hdr || v_len || v_ck;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && act) begin
      if (pos_q == POS_ID) begin
        id_q <= rx_i.rx_byte;
      end
      if (pos_q == POS_LENGTH) begin
        len_q <= rx_i.rx_byte;
      end
      if (pos_q == POS_ERROR) begin
        err_q <= rx_i.rx_byte;
      end
    end
    if (cmd_i.start) begin
      emit_cnt_q <= '0;
      last_idx_q <= last_idx_d;
      nodata_q   <= (count == 8'd0);
    end else if (cmd_i.step) begin
      emit_cnt_q <= emit_cnt_q + 4'd1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_err || cmd_i.load_item) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_err) begin
      o_status_q <= err_status;
      o_id_q     <= '0;
      o_err_q    <= '0;
      o_count_q  <= '0;
      o_byte_q   <= '0;
      o_index_q  <= '0;
      o_dvalid_q <= 1'b0;
      o_last_q   <= 1'b1;
    end else if (cmd_i.load_item) begin
      o_status_q <= (err_q != 8'd0) ? STATUS_FAULT : STATUS_OK;
      o_id_q     <= id_q;
      o_err_q    <= err_q;
      o_count_q  <= count;
      o_byte_q   <= nodata_q ? 8'd0 : ram_rdata;
      o_index_q  <= emit_cnt_q;
      o_dvalid_q <= !nodata_q;
      o_last_q   <= (emit_cnt_q == last_idx_q);
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = o_status_q;
  assign res_o.servo_id    = o_id_q;
  assign res_o.servo_error = o_err_q;
  assign res_o.data_count  = o_count_q;
  assign res_o.data_byte   = o_byte_q;
  assign res_o.data_index  = o_index_q;
  assign res_o.data_valid  = o_dvalid_q;
  assign res_o.last        = o_last_q;

endmodule

### rtl/servo_reply_frame_parser.sv
// ----------------------------------------------------------------------------
// servo_reply_frame_parser
// Streaming parser of servo reply frames: header check, length, error byte,
// data store and checksum, one result item per stored data byte, or a single item for a frame with none.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while parsing, as long as the output register
// is free or being drained; a byte whose verdict is an error leaves a single
// item in the output register. After a matching checksum byte the input
// stalls while the data run is delivered, up to 16 items: each is a store read
// and then an output load, as the read port of the data store is registered.
// Only the first DATA_STORE_DEPTH data bytes are kept; data_count
// always reports the full count. The header register is written through the
// configuration channel, which is always ready.
module servo_reply_frame_parser import sfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfp_rx_if.sink    rx_i,
  sfp_res_if.source res_o,
  sfp_cfg_if.sink   cfg_i
);

  sfp_cmd_t  cmd;
  sfp_stat_t stat;

  sfp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  sfp_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .res_o  (res_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of servo_reply_frame_parser. Received bytes go in as buffers:
// a short table of directed bytes first, then random frames, broken frames
// and noise under several header settings. A behavioral copy of the parser
// predicts every reply item, and each item that comes out is checked field by
// field against the oldest prediction. Both channels idle at random; the
// reply side also holds off for one long stretch.
// ----------------------------------------------------------------------------
module tb_top import sfp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 250;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] servo_id;
    logic [7:0] servo_error;
    logic [7:0] data_count;
    logic [7:0] data_byte;
    logic [3:0] data_index;
    logic       data_valid;
    logic       last;
  } reply_item_t;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        eob;
    logic        typed;
    reply_item_t want;
  } stim_row_t;

  localparam reply_item_t NO_REPLY     = '0;
  localparam reply_item_t SHORT_REPLY  = '{status: STATUS_SHORT, last: 1'b1, default: '0};
  localparam reply_item_t HEADER_REPLY = '{status: STATUS_HEADER, last: 1'b1, default: '0};
  localparam reply_item_t EMPTY_REPLY  = '{status: STATUS_OK, last: 1'b1, default: '0};

  // header 0xFF after reset
  localparam stim_row_t DIRECTED_ROWS [27] = '{
    // wrong header byte, buffer ends at once: short wins
    '{8'h00, 1'b1, 1'b1, SHORT_REPLY},
    // bad header, verdict on sixth byte, end on the same byte
    '{8'h00, 1'b0, 1'b0, NO_REPLY},
    '{8'hFF, 1'b0, 1'b0, NO_REPLY},
    '{8'h01, 1'b0, 1'b0, NO_REPLY},
    '{8'h02, 1'b0, 1'b0, NO_REPLY},
    '{8'h00, 1'b0, 1'b0, NO_REPLY},
    '{8'h55, 1'b1, 1'b1, HEADER_REPLY},
    // length 0
    '{8'hFF, 1'b0, 1'b0, NO_REPLY},
    '{8'hFF, 1'b0, 1'b0, NO_REPLY},
    '{8'h01, 1'b0, 1'b0, NO_REPLY},
    '{8'h00, 1'b0, 1'b0, NO_REPLY},
    '{8'h00, 1'b0, 1'b0, NO_REPLY},
    '{8'hAA, 1'b1, 1'b1, SHORT_REPLY},
    // good frame without data, one byte after the verdict
    '{8'hFF, 1'b0, 1'b0, NO_REPLY},
    '{8'hFF, 1'b0, 1'b0, NO_REPLY},
    '{8'h00, 1'b0, 1'b0, NO_REPLY},
    '{8'h02, 1'b0, 1'b0, NO_REPLY},
    '{8'h00, 1'b0, 1'b0, NO_REPLY},
    '{8'hFD, 1'b0, 1'b1, EMPTY_REPLY},
    '{8'h33, 1'b1, 1'b0, NO_REPLY},
    // id 0xFF, servo fault, data 0x00 and 0xFF
    '{8'hFF, 1'b0, 1'b0, NO_REPLY},
    '{8'hFF, 1'b0, 1'b0, NO_REPLY},
    '{8'hFF, 1'b0, 1'b0, NO_REPLY},
    '{8'h04, 1'b0, 1'b0, NO_REPLY},
    '{8'h80, 1'b0, 1'b0, NO_REPLY},
    '{8'h00, 1'b0, 1'b0, NO_REPLY},
    '{8'hFF, 1'b0, 1'b0, NO_REPLY}
  };

  logic clk_i;
  logic rst_ni;

  sfp_rx_if  rx_ch ();
  sfp_res_if res_ch ();
  sfp_cfg_if cfg_ch ();

  servo_reply_frame_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // parser copy
  logic [7:0] hdr_cfg;
  logic [8:0] byte_pos;
  logic       hdr_wrong;
  logic [7:0] frm_id;
  logic [7:0] frm_len;
  logic [7:0] frm_err;
  logic [7:0] csum;
  logic [7:0] data_stash [DATA_STORE_DEPTH];
  logic       frame_done;

  reply_item_t new_replies [$];
  reply_item_t expected_replies [$];

  int mismatches = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;
  bit tx_burst = 1'b0;
  bit rcv_burst = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clear_frame();
    byte_pos = '0;
    hdr_wrong = 1'b0;
    frm_id = '0;
    frm_len = '0;
    frm_err = '0;
    csum = '0;
    frame_done = 1'b0;
  endfunction

  function automatic reply_item_t verdict_reply(input logic [2:0] st);
    reply_item_t it;
    it = '0;
    it.status = st;
    it.last = 1'b1;
    return it;
  endfunction

  // replies caused by one received byte go to new_replies
  function automatic void predict_replies(input logic [7:0] b, input logic eob);
    reply_item_t it;
    int n_store;
    int didx;
    new_replies.delete();
    if (!frame_done) begin
      if (byte_pos < POS_ID) begin
        if (b != hdr_cfg) hdr_wrong = 1'b1;
      end else if (byte_pos == POS_ID) begin
        frm_id = b;
        csum = csum + b;
      end else if (byte_pos == POS_LENGTH) begin
        frm_len = b;
        csum = csum + b;
      end else if (byte_pos == POS_ERROR) begin
        frm_err = b;
        csum = csum + b;
      end else if (hdr_wrong) begin
        new_replies.push_back(verdict_reply(STATUS_HEADER));
        frame_done = 1'b1;
      end else if (frm_len < MIN_LENGTH) begin
        new_replies.push_back(verdict_reply(STATUS_SHORT));
        frame_done = 1'b1;
      end else if (byte_pos == {1'b0, frm_len} + CHECKSUM_OFS) begin
        frame_done = 1'b1;
        if (~csum != b) begin
          new_replies.push_back(verdict_reply(STATUS_CHECKSUM));
        end else begin
          n_store = frm_len - MIN_LENGTH;
          if (n_store > ITEM_LIM) n_store = ITEM_LIM;
          it = '0;
          it.status = (frm_err != 8'h00) ? STATUS_FAULT : STATUS_OK;
          it.servo_id = frm_id;
          it.servo_error = frm_err;
          it.data_count = frm_len - MIN_LENGTH;
          if (n_store == 0) begin
            it.last = 1'b1;
            new_replies.push_back(it);
          end else begin
            for (int i = 0; i < n_store; i++) begin
              it.data_byte = data_stash[i];
              it.data_index = 4'(i);
              it.data_valid = 1'b1;
              it.last = (i == n_store - 1);
              new_replies.push_back(it);
            end
          end
        end
      end else begin
        didx = byte_pos - POS_FIRST_DATA;
        if (didx < DATA_STORE_DEPTH) data_stash[didx] = b;
        csum = csum + b;
      end
      if (!frame_done && eob) begin
        new_replies.push_back(verdict_reply(STATUS_SHORT));
        frame_done = 1'b1;
      end
      if (byte_pos < POS_MAX) byte_pos = byte_pos + 9'd1;
    end
    if (eob) clear_frame();
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eob, input logic typed,
                           input reply_item_t want);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    rx_ch.end_of_buffer <= eob;
    @(posedge clk_i);
    while (!rx_ch.ready) @(posedge clk_i);
    predict_replies(b, eob);
    if (typed) begin
      expected_replies.push_back(want);
    end else begin
      foreach (new_replies[k]) expected_replies.push_back(new_replies[k]);
    end
    bytes_sent++;
  endtask

  // sender goes quiet until every predicted reply is out
  task automatic drain();
    rx_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_header(input logic [7:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.header_value <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    hdr_cfg = v;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] header_byte(input bit noisy);
    if (noisy && $urandom_range(0, 9) == 0) return 8'($urandom);
    return hdr_cfg;
  endfunction

  task automatic send_frame(input int len, input bit corrupt, input bit cut, input int trail,
                            input bit noisy);
    logic [7:0] frame_q [$];
    logic [7:0] id_b, err_b, d, sum;
    int n_data;
    id_b = 8'($urandom);
    err_b = ($urandom_range(0, 4) < 3) ? 8'h00 : 8'($urandom);
    n_data = (len >= 2) ? len - 2 : 0;
    frame_q = {header_byte(noisy), header_byte(noisy), id_b, 8'(len), err_b};
    sum = id_b + 8'(len) + err_b;
    for (int i = 0; i < n_data; i++) begin
      d = 8'($urandom);
      frame_q.push_back(d);
      sum = sum + d;
    end
    sum = ~sum;
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    frame_q.push_back(sum);
    if (cut) frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 2)];
    repeat (trail) frame_q.push_back(8'($urandom));
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, NO_REPLY);
  endtask

  task automatic send_random_buffer();
    int pick, len, n;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1, 1'b0, NO_REPLY);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 5) len = $urandom_range(0, 1);
      else if (pick < 85) len = $urandom_range(2, 12);
      else if (pick < 97) len = $urandom_range(13, 40);
      else len = $urandom_range(41, 120);
      send_frame(len, $urandom_range(0, 6) == 0, $urandom_range(0, 7) == 0,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, 1'b1);
    end
  endtask

  function automatic void check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : reply_check
    reply_item_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_replies.size() == 0) begin
        $error("reply with none predicted: status %0d id 0x%0h", res_ch.status,
               res_ch.servo_id);
        mismatches++;
      end else begin
        want = expected_replies.pop_front();
        check_field("status", want.status, res_ch.status);
        check_field("servo_id", want.servo_id, res_ch.servo_id);
        check_field("servo_error", want.servo_error, res_ch.servo_error);
        check_field("data_count", want.data_count, res_ch.data_count);
        check_field("data_byte", want.data_byte, res_ch.data_byte);
        check_field("data_index", want.data_index, res_ch.data_index);
        check_field("data_valid", want.data_valid, res_ch.data_valid);
        check_field("last", want.last, res_ch.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reply side: random hold-offs, one long one to back up the byte channel
  initial begin : reply_sink
    int hold;
    int taken;
    bit long_done;
    taken = 0;
    long_done = 1'b0;
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) rcv_burst = !rcv_burst;
      hold = rcv_burst ? 0 : $urandom_range(0, 9);
      if (taken == 30 && !long_done) begin
        hold = LONG_HOLD;
        long_done = 1'b1;
      end
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
      taken++;
    end
  end

  initial begin
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= '0;
    rx_ch.end_of_buffer <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.header_value <= '0;
    rst_ni <= 1'b0;
    hdr_cfg = HEADER_RESET;
    clear_frame();
    foreach (data_stash[i]) data_stash[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      send_byte(DIRECTED_ROWS[i].rx_byte, DIRECTED_ROWS[i].eob, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].want);
    end
    // checksum byte of the fault frame above, ends the buffer
    send_byte(8'h7D, 1'b1, 1'b0, NO_REPLY);

    write_header(8'h00);
    while (bytes_sent < 80) send_random_buffer();

    write_header(8'($urandom_range(1, 254)));
    while (bytes_sent < 120) send_random_buffer();
    drain();
    while (bytes_sent < 150) send_random_buffer();

    write_header(8'hFF);
    // longest frame: data_count 253, only the first bytes come back
    send_frame(255, 1'b0, 1'b0, 0, 1'b0);
    while (bytes_sent < 420) send_random_buffer();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
